// ----- rtl/core/bor_pkg.sv -----
// shared types and constants for the box overlap relation pipeline
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package bor_pkg;

   localparam int COORD_BITS     = 12;
   localparam int AREA_BITS      = 2 * COORD_BITS;
   localparam int UNION_BITS     = AREA_BITS + 1;
   localparam int THR_BITS       = 17;
   localparam int Q_FRAC         = 16;
   localparam int LHS_BITS       = AREA_BITS + Q_FRAC;
   localparam int IOU_PROD_BITS  = THR_BITS + UNION_BITS;
   localparam int CONT_PROD_BITS = THR_BITS + AREA_BITS;
   localparam int CSR_IDX_BITS   = 2;
   localparam int PIPE_LATENCY   = 5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IOU_THR  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONT_THR = 2'd1;

   localparam logic [THR_BITS-1:0] IOU_THR_RESET  = 17'd1311;
   localparam logic [THR_BITS-1:0] CONT_THR_RESET = 17'd13107;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [AREA_BITS-1:0]  area_type;

   typedef enum logic [1:0] {
      REL_NONE    = 2'd0,
      REL_A_IN_B  = 2'd1,
      REL_B_IN_A  = 2'd2,
      REL_OVERLAP = 2'd3
   } rel_type;

   typedef struct packed {
      logic [THR_BITS-1:0] iou;
      logic [THR_BITS-1:0] cont;
   } thr_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type width;
      coord_type height;
   } box_type;

   // overlap extents plus box sizes, out of the span stage
   typedef struct packed {
      coord_type iw;
      coord_type ih;
      coord_type aw;
      coord_type ah;
      coord_type bw;
      coord_type bh;
   } span_type;

   typedef struct packed {
      area_type inter;
      area_type area_a;
      area_type area_b;
   } areas_type;

endpackage

// ----- rtl/core/bor_csr.sv -----
// threshold register file behind the csr write channel
// depends on bor_pkg
`timescale 1ns / 1ps

module bor_csr
   import bor_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [THR_BITS-1:0]     csr_wdata,
   output thr_type                 thr
);

   thr_type thr_ff, thr_in;
   logic    wr_en;

   assign csr_ready = !reset;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      thr_in = thr_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_IOU_THR:  thr_in.iou  = csr_wdata;
            CSR_CONT_THR: thr_in.cont = csr_wdata;
            default: ; // unmapped index, word dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.iou  <= IOU_THR_RESET;
         thr_ff.cont <= CONT_THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign thr = thr_ff;

endmodule

// ----- rtl/core/bor_span.sv -----
// stage 1: per-axis clipped overlap of the two boxes
// depends on bor_pkg
`timescale 1ns / 1ps

module bor_span
   import bor_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  box_type  box_a,
   input  box_type  box_b,
   output logic     out_valid,
   output span_type out_span
);

   logic                valid_ff;
   span_type            span_ff, span_in;
   logic [COORD_BITS:0] ax_hi, bx_hi, ay_hi, by_hi;
   logic [COORD_BITS:0] x_lo, x_hi, y_lo, y_hi;
   logic [COORD_BITS:0] x_diff, y_diff;

   // edges carry one extra bit so nothing wraps past the frame
   always_comb begin
      ax_hi = {1'b0, box_a.left} + {1'b0, box_a.width};
      bx_hi = {1'b0, box_b.left} + {1'b0, box_b.width};
      ay_hi = {1'b0, box_a.top}  + {1'b0, box_a.height};
      by_hi = {1'b0, box_b.top}  + {1'b0, box_b.height};
      x_lo  = (box_a.left > box_b.left) ? {1'b0, box_a.left} : {1'b0, box_b.left};
      y_lo  = (box_a.top  > box_b.top)  ? {1'b0, box_a.top}  : {1'b0, box_b.top};
      x_hi  = (ax_hi < bx_hi) ? ax_hi : bx_hi;
      y_hi  = (ay_hi < by_hi) ? ay_hi : by_hi;
      x_diff = (x_hi > x_lo) ? (x_hi - x_lo) : '0;
      y_diff = (y_hi > y_lo) ? (y_hi - y_lo) : '0;
      // overlap never exceeds the shorter side, so it fits coord width
      span_in.iw = x_diff[COORD_BITS-1:0];
      span_in.ih = y_diff[COORD_BITS-1:0];
      span_in.aw = box_a.width;
      span_in.ah = box_a.height;
      span_in.bw = box_b.width;
      span_in.bh = box_b.height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   assign out_valid = valid_ff;
   assign out_span  = span_ff;

endmodule

// ----- rtl/core/bor_area.sv -----
// stage 2: intersection area and both box areas, three small multipliers
// depends on bor_pkg
`timescale 1ns / 1ps

module bor_area
   import bor_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  span_type  in_span,
   output logic      out_valid,
   output areas_type out_areas
);

   logic      valid_ff;
   areas_type areas_ff, areas_in;

   always_comb begin
      areas_in.inter  = {{COORD_BITS{1'b0}}, in_span.iw} * {{COORD_BITS{1'b0}}, in_span.ih};
      areas_in.area_a = {{COORD_BITS{1'b0}}, in_span.aw} * {{COORD_BITS{1'b0}}, in_span.ah};
      areas_in.area_b = {{COORD_BITS{1'b0}}, in_span.bw} * {{COORD_BITS{1'b0}}, in_span.bh};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      areas_ff <= areas_in;
   end

   assign out_valid = valid_ff;
   assign out_areas = areas_ff;

endmodule

// ----- rtl/core/bor_decide.sv -----
// stages 3 to 5: early classification, threshold products, final compare
// depends on bor_pkg
`timescale 1ns / 1ps

module bor_decide
   import bor_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  areas_type in_areas,
   input  thr_type   thr,
   output logic      out_valid,
   output rel_type   out_rel
);

   // stage 3
   logic                  s3_valid_ff;
   logic                  s3_done_ff, s3_done_in;
   rel_type               s3_rel_ff, s3_rel_in;
   area_type              s3_inter_ff, s3_area_a_ff, s3_area_b_ff;
   logic [UNION_BITS-1:0] s3_union_ff, s3_union_in;
   // stage 4
   logic                      s4_valid_ff;
   logic                      s4_done_ff;
   rel_type                   s4_rel_ff;
   logic [LHS_BITS-1:0]       s4_lhs_ff;
   logic [IOU_PROD_BITS-1:0]  s4_iou_ff, s4_iou_in;
   logic [CONT_PROD_BITS-1:0] s4_ca_ff, s4_ca_in, s4_cb_ff, s4_cb_in;
   // stage 5
   logic    rsp_valid_ff;
   rel_type rsp_rel_ff, rsp_rel_in;
   logic    overlap;

   // empty pairs and containment settle without the threshold path
   always_comb begin
      s3_done_in = 1'b1;
      s3_rel_in  = REL_NONE;
      if (in_areas.area_a == '0 || in_areas.area_b == '0 || in_areas.inter == '0) begin
         s3_rel_in = REL_NONE;
      end else if (in_areas.inter >= in_areas.area_a) begin
         s3_rel_in = REL_A_IN_B;
      end else if (in_areas.inter >= in_areas.area_b) begin
         s3_rel_in = REL_B_IN_A;
      end else begin
         s3_done_in = 1'b0;
      end
      s3_union_in = {1'b0, in_areas.area_a} + {1'b0, in_areas.area_b}
                    - {1'b0, in_areas.inter};
   end

   always_comb begin
      s4_iou_in = {{UNION_BITS{1'b0}}, thr.iou} * {{THR_BITS{1'b0}}, s3_union_ff};
      s4_ca_in  = {{AREA_BITS{1'b0}}, thr.cont} * {{THR_BITS{1'b0}}, s3_area_a_ff};
      s4_cb_in  = {{AREA_BITS{1'b0}}, thr.cont} * {{THR_BITS{1'b0}}, s3_area_b_ff};
   end

   always_comb begin
      overlap = ({{(IOU_PROD_BITS-LHS_BITS){1'b0}}, s4_lhs_ff} >= s4_iou_ff)
             || ({{(CONT_PROD_BITS-LHS_BITS){1'b0}}, s4_lhs_ff} > s4_ca_ff)
             || ({{(CONT_PROD_BITS-LHS_BITS){1'b0}}, s4_lhs_ff} > s4_cb_ff);
      if (s4_done_ff) begin
         rsp_rel_in = s4_rel_ff;
      end else if (overlap) begin
         rsp_rel_in = REL_OVERLAP;
      end else begin
         rsp_rel_in = REL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= in_valid;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_done_ff   <= s3_done_in;
      s3_rel_ff    <= s3_rel_in;
      s3_inter_ff  <= in_areas.inter;
      s3_area_a_ff <= in_areas.area_a;
      s3_area_b_ff <= in_areas.area_b;
      s3_union_ff  <= s3_union_in;
      s4_done_ff   <= s3_done_ff;
      s4_rel_ff    <= s3_rel_ff;
      s4_lhs_ff    <= {s3_inter_ff, {Q_FRAC{1'b0}}};
      s4_iou_ff    <= s4_iou_in;
      s4_ca_ff     <= s4_ca_in;
      s4_cb_ff     <= s4_cb_in;
      rsp_rel_ff   <= rsp_rel_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rel   = rsp_rel_ff;

endmodule

// ----- rtl/core/box_overlap_relation.sv -----
// top level of the box overlap relation block
// depends on bor_pkg, bor_csr, bor_span, bor_area, bor_decide
`timescale 1ns / 1ps

// Classifies a pair of boxes as none, A inside B, B inside A or overlapping.
// A new pair is taken on every clock while start is high; busy is high only
// during reset. Each pair yields one relation word on rsp_relation, marked by
// rsp_valid for a single cycle, once it has passed in order through the five
// pipeline registers: clipped spans, area multipliers, early classification,
// threshold multipliers and the final compare. There is no way to hold
// results back, so the receiver must take every word as it comes. Thresholds
// are written over the csr channel, index 0 for the IoU threshold and index 1
// for the containment threshold, both unsigned Q1.16; write them only while
// no pair is in flight.
module box_overlap_relation
   import bor_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [COORD_BITS-1:0]   req_a_left,
   input  logic [COORD_BITS-1:0]   req_a_top,
   input  logic [COORD_BITS-1:0]   req_a_width,
   input  logic [COORD_BITS-1:0]   req_a_height,
   input  logic [COORD_BITS-1:0]   req_b_left,
   input  logic [COORD_BITS-1:0]   req_b_top,
   input  logic [COORD_BITS-1:0]   req_b_width,
   input  logic [COORD_BITS-1:0]   req_b_height,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_relation,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [THR_BITS-1:0]     csr_wdata
);

   thr_type   thr;
   box_type   box_a, box_b;
   logic      accept;
   logic      span_valid, area_valid;
   span_type  span;
   areas_type areas;
   rel_type   rel;

   assign busy   = reset;
   assign accept = start && !busy;

   assign box_a = '{left: req_a_left, top: req_a_top,
                    width: req_a_width, height: req_a_height};
   assign box_b = '{left: req_b_left, top: req_b_top,
                    width: req_b_width, height: req_b_height};

   bor_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .thr       (thr)
   );

   bor_span u_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .box_a     (box_a),
      .box_b     (box_b),
      .out_valid (span_valid),
      .out_span  (span)
   );

   bor_area u_area (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (span_valid),
      .in_span   (span),
      .out_valid (area_valid),
      .out_areas (areas)
   );

   bor_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (area_valid),
      .in_areas  (areas),
      .thr       (thr),
      .out_valid (rsp_valid),
      .out_rel   (rel)
   );

   assign rsp_relation = rel;

endmodule

// ----- rtl/core/bor_checker.sv -----
// port-level checks for box_overlap_relation, attached by bind
// depends on bor_pkg and the top level port list
`timescale 1ns / 1ps

module bor_checker
   import bor_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [COORD_BITS-1:0] req_a_left,
   input logic [COORD_BITS-1:0] req_a_top,
   input logic [COORD_BITS-1:0] req_a_width,
   input logic [COORD_BITS-1:0] req_a_height,
   input logic [COORD_BITS-1:0] req_b_left,
   input logic [COORD_BITS-1:0] req_b_top,
   input logic [COORD_BITS-1:0] req_b_width,
   input logic [COORD_BITS-1:0] req_b_height,
   input logic                  rsp_valid,
   input logic [1:0]            rsp_relation
);

   logic accept;
   logic same_box;

   assign accept   = start && !busy;
   assign same_box = (req_a_left == req_b_left) && (req_a_top == req_b_top)
                  && (req_a_width == req_b_width) && (req_a_height == req_b_height);

   // every taken pair yields exactly one word, a fixed latency later
   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("no result word five cycles after an accepted pair");

   a_word_has_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result word without a matching accepted pair");

   // a flat box (A of zero width or B of zero height) never relates to anything
   a_flat_is_none: assert property (@(posedge clock) disable iff (reset)
      accept && (req_a_width == '0 || req_b_height == '0)
      |-> ##5 (rsp_relation == REL_NONE))
      else $error("flat box gave a relation other than none");

   // identical boxes resolve as A inside B
   a_same_is_a_in_b: assert property (@(posedge clock) disable iff (reset)
      accept && same_box && req_a_width != '0 && req_a_height != '0
      |-> ##5 (rsp_relation == REL_A_IN_B))
      else $error("identical boxes not classified as A inside B");

endmodule

bind box_overlap_relation bor_checker u_bor_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_a_left   (req_a_left),
   .req_a_top    (req_a_top),
   .req_a_width  (req_a_width),
   .req_a_height (req_a_height),
   .req_b_left   (req_b_left),
   .req_b_top    (req_b_top),
   .req_b_width  (req_b_width),
   .req_b_height (req_b_height),
   .rsp_valid    (rsp_valid),
   .rsp_relation (rsp_relation)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for box_overlap_relation: directed and random box pairs
// depends on bor_pkg and the box_overlap_relation rtl; nothing else
`timescale 1ns / 1ps

module tb_top;
   import bor_pkg::*;

   localparam int CLK_HALF_NS  = 5;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int PHASE_ITEMS  = 133;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam logic [THR_BITS-1:0] THR_ONE = 17'd65536;
   localparam logic [THR_BITS-1:0] THR_MAX = 17'h1FFFF;

   // indexes past the two thresholds are decoded as nothing
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      box_type a;
      box_type b;
   } pair_type;

   typedef enum int {
      PAIR_NOISE,
      PAIR_NEAR,
      PAIR_INSIDE,
      PAIR_EQUAL,
      PAIR_DEGENERATE,
      PAIR_EDGE
   } pair_kind_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [COORD_BITS-1:0]   req_a_left = '0;
   logic [COORD_BITS-1:0]   req_a_top = '0;
   logic [COORD_BITS-1:0]   req_a_width = '0;
   logic [COORD_BITS-1:0]   req_a_height = '0;
   logic [COORD_BITS-1:0]   req_b_left = '0;
   logic [COORD_BITS-1:0]   req_b_top = '0;
   logic [COORD_BITS-1:0]   req_b_width = '0;
   logic [COORD_BITS-1:0]   req_b_height = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_relation;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [THR_BITS-1:0]     csr_wdata = '0;

   // local copy of the threshold registers
   logic [THR_BITS-1:0] iou_thr_copy = IOU_THR_RESET;
   logic [THR_BITS-1:0] cont_thr_copy = CONT_THR_RESET;

   pair_type pair_pending[$];
   rel_type  relation_due[$];
   pair_type drive_pair;
   rel_type  expected_rel;
   int       fail_count = 0;
   int       accept_count = 0;
   int       gap_left = 0;
   bit       calm = 1'b0;
   bit       quiet_tail = 1'b0;
   bit       drain_pause = 1'b0;

   box_overlap_relation u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_a_left   (req_a_left),
      .req_a_top    (req_a_top),
      .req_a_width  (req_a_width),
      .req_a_height (req_a_height),
      .req_b_left   (req_b_left),
      .req_b_top    (req_b_top),
      .req_b_width  (req_b_width),
      .req_b_height (req_b_height),
      .rsp_valid    (rsp_valid),
      .rsp_relation (rsp_relation),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   function automatic coord_type span_len(input coord_type lo_a, input coord_type len_a,
                                          input coord_type lo_b, input coord_type len_b);
      logic [COORD_BITS:0] hi_a;
      logic [COORD_BITS:0] hi_b;
      logic [COORD_BITS:0] lo;
      logic [COORD_BITS:0] hi;
      // edges carry one extra bit so boxes past the edge do not wrap
      hi_a = {1'b0, lo_a} + {1'b0, len_a};
      hi_b = {1'b0, lo_b} + {1'b0, len_b};
      lo = (lo_a > lo_b) ? {1'b0, lo_a} : {1'b0, lo_b};
      hi = (hi_a < hi_b) ? hi_a : hi_b;
      if (hi > lo) begin
         return coord_type'(hi - lo);
      end
      return '0;
   endfunction

   function automatic rel_type classify_pair(input pair_type p,
                                             input logic [THR_BITS-1:0] iou_thr,
                                             input logic [THR_BITS-1:0] cont_thr);
      coord_type                 iw;
      coord_type                 ih;
      area_type                  inter;
      area_type                  area_a;
      area_type                  area_b;
      logic [UNION_BITS-1:0]     uni;
      logic [LHS_BITS-1:0]       lhs;
      logic [IOU_PROD_BITS-1:0]  iou_prod;
      logic [CONT_PROD_BITS-1:0] cont_a;
      logic [CONT_PROD_BITS-1:0] cont_b;
      iw = span_len(p.a.left, p.a.width, p.b.left, p.b.width);
      ih = span_len(p.a.top, p.a.height, p.b.top, p.b.height);
      inter = {{COORD_BITS{1'b0}}, iw} * {{COORD_BITS{1'b0}}, ih};
      area_a = {{COORD_BITS{1'b0}}, p.a.width} * {{COORD_BITS{1'b0}}, p.a.height};
      area_b = {{COORD_BITS{1'b0}}, p.b.width} * {{COORD_BITS{1'b0}}, p.b.height};
      if (area_a == '0 || area_b == '0 || inter == '0) begin
         return REL_NONE;
      end
      // equal boxes fall into the first containment test
      if (inter >= area_a) begin
         return REL_A_IN_B;
      end
      if (inter >= area_b) begin
         return REL_B_IN_A;
      end
      uni = {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};
      lhs = {inter, {Q_FRAC{1'b0}}};
      iou_prod = {{UNION_BITS{1'b0}}, iou_thr} * {{THR_BITS{1'b0}}, uni};
      cont_a = {{AREA_BITS{1'b0}}, cont_thr} * {{THR_BITS{1'b0}}, area_a};
      cont_b = {{AREA_BITS{1'b0}}, cont_thr} * {{THR_BITS{1'b0}}, area_b};
      if (({{(IOU_PROD_BITS-LHS_BITS){1'b0}}, lhs} >= iou_prod)
          || ({{(CONT_PROD_BITS-LHS_BITS){1'b0}}, lhs} > cont_a)
          || ({{(CONT_PROD_BITS-LHS_BITS){1'b0}}, lhs} > cont_b)) begin
         return REL_OVERLAP;
      end
      return REL_NONE;
   endfunction

   function automatic box_type box_of(input int l, input int t, input int w, input int h);
      box_type bx;
      bx.left = coord_type'(l);
      bx.top = coord_type'(t);
      bx.width = coord_type'(w);
      bx.height = coord_type'(h);
      return bx;
   endfunction

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > COORD_MAX) begin
         return coord_type'(COORD_MAX);
      end
      return coord_type'(v);
   endfunction

   // mostly small sizes so ratios land near the thresholds
   function automatic coord_type pick_size();
      if ($urandom_range(0, 1) == 0) begin
         return coord_type'($urandom_range(1, 64));
      end
      return coord_type'($urandom_range(0, COORD_MAX));
   endfunction

   function automatic coord_type jitter(input coord_type base, input coord_type span);
      return clamp_coord(int'(base) + int'($urandom_range(0, 2 * span)) - int'(span));
   endfunction

   function automatic pair_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return PAIR_NOISE;
      if (roll < 55) return PAIR_NEAR;
      if (roll < 70) return PAIR_INSIDE;
      if (roll < 75) return PAIR_EQUAL;
      if (roll < 85) return PAIR_DEGENERATE;
      return PAIR_EDGE;
   endfunction

   function automatic pair_type make_pair(input pair_kind_type kind);
      pair_type p;
      box_type  swap_box;
      p.a = box_type'({$urandom, $urandom});
      p.b = box_type'({$urandom, $urandom});
      case (kind)
         PAIR_NOISE: begin
         end
         PAIR_NEAR, PAIR_DEGENERATE: begin
            p.a.width = pick_size();
            p.a.height = pick_size();
            p.b.width = jitter(p.a.width, p.a.width);
            p.b.height = jitter(p.a.height, p.a.height);
            p.b.left = jitter(p.a.left, p.a.width);
            p.b.top = jitter(p.a.top, p.a.height);
            if (kind == PAIR_DEGENERATE) begin
               case ($urandom_range(0, 3))
                  0: p.a.width = '0;
                  1: p.a.height = '0;
                  2: p.b.width = '0;
                  default: p.b.height = '0;
               endcase
            end
         end
         PAIR_INSIDE: begin
            p.a.width = clamp_coord(int'(pick_size()) + 1);
            p.a.height = clamp_coord(int'(pick_size()) + 1);
            p.b.width = coord_type'($urandom_range(1, p.a.width));
            p.b.height = coord_type'($urandom_range(1, p.a.height));
            p.b.left = clamp_coord(int'(p.a.left) +
                                   int'($urandom_range(0, p.a.width - p.b.width)));
            p.b.top = clamp_coord(int'(p.a.top) +
                                  int'($urandom_range(0, p.a.height - p.b.height)));
            if ($urandom_range(0, 1) == 1) begin
               swap_box = p.a;
               p.a = p.b;
               p.b = swap_box;
            end
         end
         PAIR_EQUAL: begin
            p.b = p.a;
         end
         default: begin
            // both boxes sit near the far edge of the coordinate range and may run past it
            p.a.left = coord_type'($urandom_range(COORD_MAX - 200, COORD_MAX));
            p.a.top = coord_type'($urandom_range(COORD_MAX - 200, COORD_MAX));
            p.b.left = coord_type'($urandom_range(COORD_MAX - 200, COORD_MAX));
            p.b.top = coord_type'($urandom_range(COORD_MAX - 200, COORD_MAX));
            p.a.width = coord_type'($urandom_range(1, COORD_MAX));
            p.b.height = coord_type'($urandom_range(1, COORD_MAX));
         end
      endcase
      return p;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // append a pair to the driver queue
   task automatic queue_pair(input pair_type p);
      pair_pending.insert(pair_pending.size(), p);
   endtask

   // append an expected relation behind the ones already due
   task automatic expect_relation(input rel_type r);
      relation_due.insert(relation_due.size(), r);
   endtask

   task automatic write_threshold(input logic [CSR_IDX_BITS-1:0] idx,
                                  input logic [THR_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IOU_THR:  iou_thr_copy = value;
         CSR_CONT_THR: cont_thr_copy = value;
         default: ;
      endcase
   endtask

   // nothing queued, nothing in flight, then let the pipeline empty
   task automatic settle_idle();
      while (pair_pending.size() != 0 || start || relation_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic run_phase(input logic [THR_BITS-1:0] iou_thr,
                            input logic [THR_BITS-1:0] cont_thr, input int count);
      write_threshold(CSR_IOU_THR, iou_thr);
      write_threshold(CSR_CONT_THR, cont_thr);
      repeat (count) queue_pair(make_pair(pick_kind()));
      settle_idle();
   endtask

   // driver: presents the next pending pair and holds it until taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expect_relation(classify_pair(drive_pair, iou_thr_copy, cont_thr_copy));
            accept_count++;
            if (accept_count % 50 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
            if (!calm && !quiet_tail && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 17);
            end
            if (accept_count == 200 || (!quiet_tail && $urandom_range(0, 199) == 0)) begin
               drain_pause = 1'b1;
            end
         end
         if (quiet_tail) begin
            gap_left = 0;
         end
         if (drain_pause && relation_due.size() == 0) begin
            drain_pause = 1'b0;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (drain_pause || pair_pending.size() == 0) begin
               start <= 1'b0;
            end else begin
               drive_pair = pair_pending.pop_front();
               req_a_left <= drive_pair.a.left;
               req_a_top <= drive_pair.a.top;
               req_a_width <= drive_pair.a.width;
               req_a_height <= drive_pair.a.height;
               req_b_left <= drive_pair.b.left;
               req_b_top <= drive_pair.b.top;
               req_b_width <= drive_pair.b.width;
               req_b_height <= drive_pair.b.height;
               start <= 1'b1;
            end
         end
      end
   end

   // monitor: every strobed word must match the oldest expected relation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (relation_due.size() == 0) begin
            report_mismatch($sformatf("relation word %0d with nothing expected",
                                      rsp_relation));
         end else begin
            expected_rel = relation_due.pop_front();
            if (rsp_relation !== expected_rel) begin
               report_mismatch($sformatf("relation got %0d want %0d (%s)",
                                         rsp_relation, expected_rel, expected_rel.name()));
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed pairs under the reset thresholds
      queue_pair({box_of(0, 0, 0, 0), box_of(0, 0, 0, 0)});
      queue_pair({box_of(4095, 4095, 4095, 4095), box_of(4095, 4095, 4095, 4095)});
      queue_pair({box_of(0, 0, 4095, 4095), box_of(4095, 4095, 4095, 4095)});
      queue_pair({box_of(0, 0, 4095, 4095), box_of(4094, 4094, 4095, 4095)});
      queue_pair({box_of(10, 10, 5, 5), box_of(0, 0, 100, 100)});
      queue_pair({box_of(0, 0, 100, 100), box_of(10, 10, 5, 5)});
      queue_pair({box_of(100, 200, 30, 40), box_of(100, 200, 30, 40)});
      queue_pair({box_of(0, 0, 10, 10), box_of(20, 20, 10, 10)});
      queue_pair({box_of(0, 0, 10, 10), box_of(10, 0, 10, 10)});
      queue_pair({box_of(0, 0, 0, 10), box_of(0, 0, 10, 10)});
      queue_pair({box_of(0, 0, 10, 10), box_of(0, 0, 10, 0)});
      queue_pair({box_of(0, 0, 10, 10), box_of(5, 0, 10, 10)});
      queue_pair({box_of(0, 0, 100, 100), box_of(99, 99, 100, 100)});
      queue_pair({box_of(0, 0, 100, 100), box_of(50, 0, 1000, 1000)});
      queue_pair({box_of(4095, 4095, 1, 1), box_of(4095, 4095, 1, 1)});
      queue_pair({box_of(30, 30, 1, 1), box_of(0, 0, 4095, 4095)});
      // cross shape: intersection over each area sits exactly on 0.2
      queue_pair({box_of(0, 40, 100, 20), box_of(40, 0, 20, 100)});
      queue_pair({box_of(4095, 0, 4095, 1), box_of(0, 4095, 1, 4095)});
      queue_pair({box_of(2730, 2730, 2730, 2730), box_of(1365, 1365, 1365, 1365)});
      settle_idle();

      // thresholds at zero: any touch of area counts as overlap
      run_phase('0, '0, PHASE_ITEMS);
      run_phase(THR_ONE, THR_ONE, PHASE_ITEMS);
      run_phase(THR_MAX, THR_MAX, PHASE_ITEMS);
      write_threshold(CSR_SPARE_A, THR_BITS'($urandom));
      write_threshold(CSR_SPARE_B, THR_BITS'($urandom));
      run_phase(THR_BITS'($urandom_range(0, 8000)), THR_BITS'($urandom_range(0, 65536)),
                PHASE_ITEMS);
      run_phase(THR_BITS'($urandom), THR_BITS'($urandom), PHASE_ITEMS);
      run_phase(THR_ONE - 17'd1, 17'd1, PHASE_ITEMS);
      quiet_tail = 1'b1;
      run_phase(IOU_THR_RESET, CONT_THR_RESET, PHASE_ITEMS);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
